// ----- rtl/core/best_fit_segment_allocator_assert.svh -----
// Assertion macros for the segment allocator
`ifndef BEST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BFSA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define BFSA_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define BFSA_ASSERT(label, clk, rst, prop)
`define BFSA_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- rtl/core/bfsa_pkg.sv -----
package bfsa_pkg;
   localparam int TableDepth = 16;
   localparam int AddrBits   = 32;
   localparam int SizeBits   = 16;

   localparam logic [31:0] HeapBaseRst   = 32'd0;
   localparam logic [16:0] PageSizeRst   = 17'd4096;
   localparam logic [6:0]  HeaderSizeRst = 7'd16;
   localparam logic [16:0] PageLimitRst  = 17'd256;

   localparam logic [1:0] CsrHeapBase   = 2'd0;
   localparam logic [1:0] CsrPageSize   = 2'd1;
   localparam logic [1:0] CsrHeaderSize = 2'd2;
   localparam logic [1:0] CsrPageLimit  = 2'd3;

   localparam logic [1:0] StOk    = 2'd0;
   localparam logic [1:0] StSize  = 2'd1;
   localparam logic [1:0] StFull  = 2'd2;
   localparam logic [1:0] StLimit = 2'd3;

   localparam logic FuncAlloc = 1'b0;
   localparam logic FuncFree  = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_FIND, S_FIND_WAIT, S_PAGE, S_ADD, S_ADD_WAIT,
      S_ADD_DONE, S_TAKE, S_TAKE_WAIT, S_SPLIT, S_DONE
   } state_type;

   // one sweep command through the cell row
   typedef enum logic [1:0] {
      OP_NONE, OP_FIND, OP_ADD, OP_TAKE
   } op_type;
endpackage

// ----- rtl/core/bfsa_cell.sv -----
// One table slot. A token travels down the row one cell per cycle; each cell
// updates the token with what it sees and may change its own entry.
module bfsa_cell #(
   parameter int ADDR_BITS = bfsa_pkg::AddrBits,
   parameter int SIZE_BITS = bfsa_pkg::SizeBits,
   parameter int IDX_BITS  = 4,
   parameter logic [IDX_BITS-1:0] MY_IDX = '0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [6:0]           header_size,
   input  logic                 tok_v_in,
   input  bfsa_pkg::op_type     tok_op_in,
   input  logic [ADDR_BITS-1:0] tok_hdr_in,
   input  logic [SIZE_BITS-1:0] tok_pay_in,
   input  logic                 tok_hit_in,
   input  logic                 tok_stop_in,
   input  logic [IDX_BITS-1:0]  tok_idx_in,
   input  logic [SIZE_BITS-1:0] tok_slack_in,
   input  logic                 tok_free_in,
   input  logic [IDX_BITS-1:0]  tok_fidx_in,
   output logic                 tok_v_ff,
   output bfsa_pkg::op_type     tok_op_ff,
   output logic [ADDR_BITS-1:0] tok_hdr_ff,
   output logic [SIZE_BITS-1:0] tok_pay_ff,
   output logic                 tok_hit_ff,
   output logic                 tok_stop_ff,
   output logic [IDX_BITS-1:0]  tok_idx_ff,
   output logic [SIZE_BITS-1:0] tok_slack_ff,
   output logic                 tok_free_ff,
   output logic [IDX_BITS-1:0]  tok_fidx_ff,
   input  logic                 place_v,
   input  logic [IDX_BITS-1:0]  place_idx,
   input  logic [ADDR_BITS-1:0] place_hdr,
   input  logic [SIZE_BITS-1:0] place_pay,
   input  logic                 clear_v,
   input  logic [IDX_BITS-1:0]  clear_idx,
   output logic                 valid_ff,
   output logic [ADDR_BITS-1:0] hdr_ff,
   output logic [SIZE_BITS-1:0] pay_ff
);
   logic [ADDR_BITS-1:0] hdr_in;
   logic [SIZE_BITS-1:0] pay_in;
   logic                 valid_in;
   logic [ADDR_BITS-1:0] e_end, n_end;
   logic [SIZE_BITS+1:0] sum;
   logic                 sum_ok, touch_lo, touch_hi, fits;
   logic [SIZE_BITS-1:0] slack;
   logic                 hit_in, stop_in, free_in;
   logic [IDX_BITS-1:0]  idx_in, fidx_in;
   logic [SIZE_BITS-1:0] slack_in;
   logic [ADDR_BITS-1:0] thdr_in;
   logic [SIZE_BITS-1:0] tpay_in;

   always_comb begin
      e_end = hdr_ff + ADDR_BITS'(header_size) + ADDR_BITS'(pay_ff);
      n_end = tok_hdr_in + ADDR_BITS'(header_size) + ADDR_BITS'(tok_pay_in);
      sum = (SIZE_BITS+2)'(pay_ff) + (SIZE_BITS+2)'(tok_pay_in)
          + (SIZE_BITS+2)'(header_size);
      sum_ok = sum[SIZE_BITS+1:SIZE_BITS] == 2'b00;
      touch_lo = e_end == tok_hdr_in;
      touch_hi = n_end == hdr_ff;
      fits = pay_ff >= tok_pay_in;
      slack = pay_ff - tok_pay_in;
      hit_in = tok_hit_in; stop_in = tok_stop_in; idx_in = tok_idx_in;
      slack_in = tok_slack_in; free_in = tok_free_in; fidx_in = tok_fidx_in;
      thdr_in = tok_hdr_in; tpay_in = tok_pay_in;
      hdr_in = hdr_ff; pay_in = pay_ff; valid_in = valid_ff;
      if (tok_v_in) begin
         case (tok_op_in)
            bfsa_pkg::OP_FIND: begin
               if (valid_ff && fits && (!tok_hit_in || slack < tok_slack_in)) begin
                  hit_in = 1'b1; idx_in = MY_IDX; slack_in = slack;
               end
               if (!valid_ff && !tok_free_in) begin
                  free_in = 1'b1; fidx_in = MY_IDX;
               end
            end
            bfsa_pkg::OP_ADD: begin
               if (!valid_ff && !tok_free_in) begin
                  free_in = 1'b1; fidx_in = MY_IDX;
               end
               if (valid_ff && !tok_stop_in && (touch_lo || touch_hi)) begin
                  stop_in = 1'b1;
                  if (sum_ok) begin
                     hit_in = 1'b1;
                     pay_in = sum[SIZE_BITS-1:0];
                     if (!touch_lo) hdr_in = tok_hdr_in;
                  end
               end
            end
            bfsa_pkg::OP_TAKE: begin
               if (tok_idx_in == MY_IDX) begin
                  thdr_in = hdr_ff; tpay_in = pay_ff; valid_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
      if (place_v && place_idx == MY_IDX) begin
         valid_in = 1'b1; hdr_in = place_hdr; pay_in = place_pay;
      end
      if (clear_v && clear_idx == MY_IDX) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
      pay_ff <= pay_in;
      tok_op_ff <= tok_op_in;
      tok_hdr_ff <= thdr_in;
      tok_pay_ff <= tpay_in;
      tok_hit_ff <= hit_in;
      tok_stop_ff <= stop_in;
      tok_idx_ff <= idx_in;
      tok_slack_ff <= slack_in;
      tok_free_ff <= free_in;
      tok_fidx_ff <= fidx_in;
      if (reset) begin
         valid_ff <= 1'b0;
         tok_v_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_v_ff <= tok_v_in;
      end
   end
endmodule

// ----- rtl/core/best_fit_segment_allocator.sv -----
// channel | dir | handshake             | content
// req     | in  | req_tvalid/req_tready | func, req_size, block_addr
// rsp     | out | rsp_tvalid/rsp_tready | status, payload_addr, page_taken, merged
// csr     | in  | csr_valid/csr_ready   | register index, write data
// One request at a time. Each table sweep is one pass of a token along the
// cell row; an allocate uses at most 5 sweeps and a free at most one. Reset
// is synchronous and clears the valid bits at once. A stalled result holds;
// the next request waits for it.
`include "best_fit_segment_allocator_assert.svh"
module best_fit_segment_allocator #(
   parameter int TABLE_DEPTH = bfsa_pkg::TableDepth,
   parameter int ADDR_BITS   = bfsa_pkg::AddrBits,
   parameter int SIZE_BITS   = bfsa_pkg::SizeBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // func
   input  logic [47:0] req_tdata,   // [15:0] req_size, [47:16] block_addr
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [1:0] status, [33:2] payload_addr, [34] page_taken,
                                    // [35] merged, [39:36] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   localparam int IB = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int AW = ADDR_BITS;
   localparam int SW = SIZE_BITS;

   logic [31:0] heap_base_ff;
   logic [16:0] page_size_ff, page_limit_ff, pages_used_ff, pages_used_in;
   logic [6:0]  header_size_ff;

   bfsa_pkg::state_type state_ff, state_in;
   logic          func_ff;
   logic [15:0]   size_ff;
   logic [31:0]   addr_ff;
   logic [1:0]    status_ff, status_in;
   logic [AW-1:0] paddr_ff, paddr_in;
   logic          taken_ff, taken_in, merged_ff, merged_in, retry_ff, retry_in;
   logic [SW-1:0] page_pay_ff, page_pay_in, rem_ff, rem_in;
   logic [AW-1:0] ahdr_ff, ahdr_in;
   logic [SW-1:0] apay_ff, apay_in;
   logic [IB-1:0] bidx_ff, bidx_in;
   logic [AW-1:0] page_hdr_ff;
   logic [AW+16:0] page_prod;

   logic               tv  [TABLE_DEPTH+1];
   bfsa_pkg::op_type   top [TABLE_DEPTH+1];
   logic [AW-1:0]      th  [TABLE_DEPTH+1];
   logic [SW-1:0]      tp  [TABLE_DEPTH+1];
   logic               thit[TABLE_DEPTH+1], tstp[TABLE_DEPTH+1], tfr[TABLE_DEPTH+1];
   logic [IB-1:0]      tix [TABLE_DEPTH+1], tfx[TABLE_DEPTH+1];
   logic [SW-1:0]      tsl [TABLE_DEPTH+1];
   logic               cv  [TABLE_DEPTH];
   logic [AW-1:0]      ch  [TABLE_DEPTH];
   logic [SW-1:0]      cp  [TABLE_DEPTH];

   logic launch;
   bfsa_pkg::op_type launch_op;
   logic place_v, clear_v;
   logic [IB-1:0] place_idx;
   logic done_v;

   assign csr_ready = state_ff == bfsa_pkg::S_IDLE;
   assign req_tready = state_ff == bfsa_pkg::S_IDLE && !rsp_tvalid;
   assign rsp_tvalid = state_ff == bfsa_pkg::S_DONE;
   assign rsp_tdata = {4'd0, merged_ff, taken_ff, 32'(paddr_ff), status_ff};
   assign done_v = tv[TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= bfsa_pkg::HeapBaseRst;
         page_size_ff <= bfsa_pkg::PageSizeRst;
         header_size_ff <= bfsa_pkg::HeaderSizeRst;
         page_limit_ff <= bfsa_pkg::PageLimitRst;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bfsa_pkg::CsrHeapBase:   heap_base_ff <= csr_data;
            bfsa_pkg::CsrPageSize:   page_size_ff <= csr_data[16:0];
            bfsa_pkg::CsrHeaderSize: header_size_ff <= csr_data[6:0];
            bfsa_pkg::CsrPageLimit:  page_limit_ff <= csr_data[16:0];
            default: ;
         endcase
      end
   end

   assign tv[0] = launch;
   assign top[0] = launch_op;
   assign th[0] = ahdr_in;
   assign tp[0] = apay_in;
   assign thit[0] = 1'b0;
   assign tstp[0] = 1'b0;
   assign tfr[0] = 1'b0;
   assign tix[0] = bidx_in;
   assign tfx[0] = '0;
   assign tsl[0] = '0;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      bfsa_cell #(.ADDR_BITS(AW), .SIZE_BITS(SW), .IDX_BITS(IB),
                  .MY_IDX(IB'(g))) u_cell (
         .clock(clock), .reset(reset), .header_size(header_size_ff),
         .tok_v_in(tv[g]), .tok_op_in(top[g]), .tok_hdr_in(th[g]),
         .tok_pay_in(tp[g]), .tok_hit_in(thit[g]), .tok_stop_in(tstp[g]),
         .tok_idx_in(tix[g]), .tok_slack_in(tsl[g]), .tok_free_in(tfr[g]),
         .tok_fidx_in(tfx[g]),
         .tok_v_ff(tv[g+1]), .tok_op_ff(top[g+1]), .tok_hdr_ff(th[g+1]),
         .tok_pay_ff(tp[g+1]), .tok_hit_ff(thit[g+1]), .tok_stop_ff(tstp[g+1]),
         .tok_idx_ff(tix[g+1]), .tok_slack_ff(tsl[g+1]), .tok_free_ff(tfr[g+1]),
         .tok_fidx_ff(tfx[g+1]),
         .place_v(place_v), .place_idx(place_idx), .place_hdr(ahdr_ff),
         .place_pay(apay_ff), .clear_v(clear_v), .clear_idx(bidx_ff),
         .valid_ff(cv[g]), .hdr_ff(ch[g]), .pay_ff(cp[g]));
   end

   // page header product registered before use
   always_ff @(posedge clock) begin
      page_prod <= (AW+17)'(pages_used_ff) * (AW+17)'(page_size_ff);
      page_hdr_ff <= AW'(heap_base_ff) + page_prod[AW-1:0];
   end

   always_comb begin
      logic [17:0] pp;
      pp = (page_size_ff > 17'(header_size_ff)) ?
           18'(page_size_ff - 17'(header_size_ff)) : 18'd0;
      if (SW < 18 && pp > 18'((64'd1 << SW) - 64'd1))
         page_pay_in = '1;
      else
         page_pay_in = SW'(pp);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfsa_pkg::S_IDLE:
            if (req_tvalid && req_tready) state_in = bfsa_pkg::S_CHECK;
         bfsa_pkg::S_CHECK:
            if (size_ff == 16'd0 || 32'(size_ff) > 32'(page_pay_ff))
               state_in = bfsa_pkg::S_DONE;
            else if (func_ff == bfsa_pkg::FuncFree) state_in = bfsa_pkg::S_ADD;
            else state_in = bfsa_pkg::S_FIND;
         bfsa_pkg::S_FIND: state_in = bfsa_pkg::S_FIND_WAIT;
         bfsa_pkg::S_FIND_WAIT:
            if (done_v) begin
               if (thit[TABLE_DEPTH]) state_in = bfsa_pkg::S_TAKE;
               else if (retry_ff || pages_used_ff >= page_limit_ff)
                  state_in = bfsa_pkg::S_DONE;
               else state_in = bfsa_pkg::S_PAGE;
            end
         bfsa_pkg::S_PAGE: state_in = bfsa_pkg::S_ADD;
         bfsa_pkg::S_ADD: state_in = bfsa_pkg::S_ADD_WAIT;
         bfsa_pkg::S_ADD_WAIT: if (done_v) state_in = bfsa_pkg::S_ADD_DONE;
         bfsa_pkg::S_ADD_DONE:
            if (func_ff == bfsa_pkg::FuncAlloc && retry_ff && status_ff == bfsa_pkg::StOk
                && !paddr_ff[0] && rem_ff == '0 && taken_ff)
               state_in = bfsa_pkg::S_FIND;
            else state_in = bfsa_pkg::S_DONE;
         bfsa_pkg::S_TAKE: state_in = bfsa_pkg::S_TAKE_WAIT;
         bfsa_pkg::S_TAKE_WAIT: if (done_v) state_in = bfsa_pkg::S_SPLIT;
         bfsa_pkg::S_SPLIT:
            if (rem_ff > SW'(header_size_ff) && (tfr[TABLE_DEPTH] || 1'b1))
               state_in = bfsa_pkg::S_ADD;
            else state_in = bfsa_pkg::S_DONE;
         bfsa_pkg::S_DONE: if (rsp_tready) state_in = bfsa_pkg::S_IDLE;
         default: state_in = bfsa_pkg::S_IDLE;
      endcase
   end

   // rem_ff is cleared for the page-add path; paddr_ff[0] is also tested in the retry condition
   always_comb begin
      launch = 1'b0; launch_op = bfsa_pkg::OP_NONE;
      place_v = 1'b0; clear_v = 1'b0; place_idx = tfx[TABLE_DEPTH];
      status_in = status_ff; paddr_in = paddr_ff; taken_in = taken_ff;
      merged_in = merged_ff; retry_in = retry_ff; rem_in = rem_ff;
      ahdr_in = ahdr_ff; apay_in = apay_ff; bidx_in = bidx_ff;
      pages_used_in = pages_used_ff;
      case (state_ff)
         bfsa_pkg::S_IDLE: begin
            status_in = bfsa_pkg::StOk; paddr_in = '0; taken_in = 1'b0;
            merged_in = 1'b0; retry_in = 1'b0; rem_in = '0;
         end
         bfsa_pkg::S_CHECK: begin
            if (size_ff == 16'd0 || 32'(size_ff) > 32'(page_pay_ff))
               status_in = bfsa_pkg::StSize;
            ahdr_in = AW'(addr_ff) - AW'(header_size_ff);
            apay_in = SW'(size_ff);
         end
         bfsa_pkg::S_FIND: begin
            launch = 1'b1; launch_op = bfsa_pkg::OP_FIND; apay_in = SW'(size_ff);
         end
         bfsa_pkg::S_FIND_WAIT:
            if (done_v) begin
               bidx_in = tix[TABLE_DEPTH];
               if (!thit[TABLE_DEPTH]) begin
                  if (retry_ff) status_in = bfsa_pkg::StSize;
                  else if (pages_used_ff >= page_limit_ff) status_in = bfsa_pkg::StLimit;
               end
            end
         bfsa_pkg::S_PAGE: begin
            ahdr_in = page_hdr_ff; apay_in = page_pay_ff; retry_in = 1'b1;
            taken_in = 1'b1;
         end
         bfsa_pkg::S_ADD: begin
            launch = 1'b1; launch_op = bfsa_pkg::OP_ADD;
         end
         bfsa_pkg::S_ADD_WAIT:
            if (done_v) begin
               if (thit[TABLE_DEPTH]) merged_in = 1'b1;
               else if (tfr[TABLE_DEPTH]) place_v = 1'b1;
               else if (rem_ff == '0) status_in = bfsa_pkg::StFull;
               if (rem_ff == '0 && taken_ff && retry_ff
                   && (thit[TABLE_DEPTH] || tfr[TABLE_DEPTH]))
                  pages_used_in = pages_used_ff + 17'd1;
               if (rem_ff == '0 && taken_ff && retry_ff
                   && !thit[TABLE_DEPTH] && !tfr[TABLE_DEPTH])
                  taken_in = 1'b0;
            end
         bfsa_pkg::S_TAKE: begin
            launch = 1'b1; launch_op = bfsa_pkg::OP_TAKE;
         end
         bfsa_pkg::S_TAKE_WAIT:
            if (done_v) begin
               clear_v = 1'b1;
               paddr_in = th[TABLE_DEPTH] + AW'(header_size_ff);
               rem_in = tp[TABLE_DEPTH] - SW'(size_ff);
            end
         bfsa_pkg::S_SPLIT: begin
            // after clearing the taken slot a free slot always exists
            ahdr_in = paddr_ff + AW'(size_ff);
            apay_in = rem_ff - SW'(header_size_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in; paddr_ff <= paddr_in; taken_ff <= taken_in;
      merged_ff <= merged_in; rem_ff <= rem_in;
      ahdr_ff <= ahdr_in; apay_ff <= apay_in; bidx_ff <= bidx_in;
      page_pay_ff <= page_pay_in;
      if (req_tvalid && req_tready) begin
         func_ff <= req_tuser; size_ff <= req_tdata[15:0];
         addr_ff <= req_tdata[47:16];
      end
      if (reset) begin
         state_ff <= bfsa_pkg::S_IDLE;
         pages_used_ff <= '0;
         retry_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pages_used_ff <= pages_used_in;
         retry_ff <= retry_in;
      end
   end

   `BFSA_ASSERT(a_no_accept_busy, clock, reset, (state_ff != bfsa_pkg::S_IDLE) |-> !req_tready)
   `BFSA_ASSERT(a_pages_step, clock, reset,
      (pages_used_ff != $past(pages_used_ff)) |->
      (pages_used_ff == $past(pages_used_ff) + 17'd1))
   `BFSA_ASSERT(a_rsp_hold, clock, reset,
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
   `BFSA_ASSERT(a_ok_addr, clock, reset,
      (rsp_tvalid && rsp_tdata[1:0] != bfsa_pkg::StOk) |-> (rsp_tdata[33:2] == 32'd0))
endmodule

// ----- tb/testbench.sv -----
module testbench;
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] payload_addr;
      logic        page_taken;
      logic        merged;
   } alloc_rsp_type;

   typedef struct {
      logic [31:0] addr;
      logic [15:0] size;
   } live_block_type;

   // shadow of the allocator: free table, page counter, registers, pending results
   class alloc_scoreboard;
      bit [31:0]       heap_base;
      bit [16:0]       page_size;
      bit [6:0]        hdr_size;
      bit [16:0]       page_limit;
      bit [31:0]       seg_hdr[bfsa_pkg::TableDepth];
      longint unsigned seg_pay[bfsa_pkg::TableDepth];
      bit              seg_vld[bfsa_pkg::TableDepth];
      longint unsigned pages_used;
      alloc_rsp_type   pending[$];
      int              errors;

      function void clear();
         heap_base  = bfsa_pkg::HeapBaseRst;
         page_size  = bfsa_pkg::PageSizeRst;
         hdr_size   = bfsa_pkg::HeaderSizeRst;
         page_limit = bfsa_pkg::PageLimitRst;
         foreach (seg_vld[i]) seg_vld[i] = 1'b0;
         pages_used = 0;
         errors     = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            bfsa_pkg::CsrHeapBase:   heap_base  = val;
            bfsa_pkg::CsrPageSize:   page_size  = val[16:0];
            bfsa_pkg::CsrHeaderSize: hdr_size   = val[6:0];
            default:                 page_limit = val[16:0];
         endcase
      endfunction

      function longint unsigned page_payload();
         longint unsigned pp;
         pp = (page_size > hdr_size) ? page_size - hdr_size : 0;
         if (pp > 65535) pp = 65535;
         return pp;
      endfunction

      function bit add_seg(bit [31:0] h, longint unsigned p, inout bit mg);
         bit [31:0]       e_end, n_end;
         longint unsigned sum;
         bit              stop;
         stop = 1'b0;
         for (int i = 0; i < bfsa_pkg::TableDepth && !stop; i++) begin
            if (seg_vld[i]) begin
               e_end = 32'(seg_hdr[i] + hdr_size + seg_pay[i]);
               n_end = 32'(h + hdr_size + p);
               sum   = seg_pay[i] + p + hdr_size;
               if (e_end == h) begin
                  if (sum <= 65535) begin
                     seg_pay[i] = sum;
                     mg = 1'b1;
                     return 1'b1;
                  end
                  stop = 1'b1;
               end else if (n_end == seg_hdr[i]) begin
                  if (sum <= 65535) begin
                     seg_hdr[i] = h;
                     seg_pay[i] = sum;
                     mg = 1'b1;
                     return 1'b1;
                  end
                  stop = 1'b1;
               end
            end
         end
         for (int i = 0; i < bfsa_pkg::TableDepth; i++) begin
            if (!seg_vld[i]) begin
               seg_vld[i] = 1'b1;
               seg_hdr[i] = h;
               seg_pay[i] = p;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function int best_slot(longint unsigned req);
         int              best;
         longint unsigned slack;
         best  = -1;
         slack = 0;
         for (int i = 0; i < bfsa_pkg::TableDepth; i++) begin
            if (seg_vld[i] && seg_pay[i] >= req && (best < 0 || seg_pay[i] - req < slack)) begin
               best  = i;
               slack = seg_pay[i] - req;
            end
         end
         return best;
      endfunction

      function bit slot_free();
         foreach (seg_vld[i]) if (!seg_vld[i]) return 1'b1;
         return 1'b0;
      endfunction

      // note an accepted request; returns the expected response
      function alloc_rsp_type note_request(logic fn, logic [15:0] req, logic [31:0] addr);
         alloc_rsp_type   r;
         longint unsigned pp, rem;
         int              slot;
         bit              mg;
         bit [31:0]       h;
         r  = '0;
         mg = 1'b0;
         pp = page_payload();
         if (req == 0 || req > pp) begin
            r.status = bfsa_pkg::StSize;
         end else if (fn == bfsa_pkg::FuncFree) begin
            if (!add_seg(32'(addr - hdr_size), 64'(req), mg)) r.status = bfsa_pkg::StFull;
         end else begin
            slot = best_slot(64'(req));
            if (slot < 0) begin
               if (pages_used >= page_limit) begin
                  r.status = bfsa_pkg::StLimit;
               end else if (add_seg(32'(heap_base + pages_used * page_size), pp, mg)) begin
                  pages_used++;
                  r.page_taken = 1'b1;
                  slot = best_slot(64'(req));
                  if (slot < 0) r.status = bfsa_pkg::StSize;
               end else begin
                  r.status = bfsa_pkg::StFull;
               end
            end
            if (r.status == bfsa_pkg::StOk && slot >= 0) begin
               h   = seg_hdr[slot];
               rem = seg_pay[slot] - req;
               seg_vld[slot] = 1'b0;
               r.payload_addr = 32'(h + hdr_size);
               if (rem > hdr_size && slot_free())
                  void'(add_seg(32'(r.payload_addr + req), rem - hdr_size, mg));
            end
         end
         r.merged = mg;
         pending.push_back(r);
         return r;
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_response(logic [39:0] d);
         alloc_rsp_type e;
         if (pending.size() == 0) begin
            report($sformatf("unexpected response %h", d));
            return;
         end
         e = pending.pop_front();
         if (d[1:0] !== e.status)
            report($sformatf("status %0d, want %0d", d[1:0], e.status));
         if (d[33:2] !== e.payload_addr)
            report($sformatf("payload_addr %h, want %h", d[33:2], e.payload_addr));
         if (d[34] !== e.page_taken)
            report($sformatf("page_taken %b, want %b", d[34], e.page_taken));
         if (d[35] !== e.merged)
            report($sformatf("merged %b, want %b", d[35], e.merged));
         if (d[39:36] !== 4'd0)
            report($sformatf("pad bits %h", d[39:36]));
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic        req_tuser = 0;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   alloc_scoreboard sb = new();
   live_block_type  live[$];
   bit              quiet;
   longint          cycles = 0;

   best_fit_segment_allocator dut (.*);

   initial forever #6 clock = ~clock;

   function int draw_gap();
      return quiet ? 0 : $urandom_range(0, 13);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);

   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = draw_gap();
         if (n > 0) begin
            rsp_tready <= 0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task send(logic fn, logic [15:0] size, logic [31:0] addr);
      alloc_rsp_type r;
      int            n;
      n = draw_gap();
      if (n > 0) begin
         req_tvalid <= 0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= fn;
      req_tdata  <= {addr, size};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = sb.note_request(fn, size, addr);
      if (fn == bfsa_pkg::FuncAlloc && r.status == bfsa_pkg::StOk)
         live.push_back('{r.payload_addr, size});
   endtask

   // csr_valid is left high; the caller drops it after the last write
   task csr_write(logic [1:0] idx, logic [31:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task run_phase(int count);
      longint unsigned pp;
      int              k, sel;
      live_block_type  b;
      pp = sb.page_payload();
      live.delete();
      // edges of the size range, bad frees
      send(bfsa_pkg::FuncAlloc, 16'd0, 32'd0);
      send(bfsa_pkg::FuncAlloc, 16'd1, 32'hFFFF_FFFF);
      send(bfsa_pkg::FuncAlloc, 16'(pp), 32'd0);
      send(bfsa_pkg::FuncAlloc, 16'(pp + 1), 32'd0);
      send(bfsa_pkg::FuncAlloc, 16'hFFFF, 32'd0);
      send(bfsa_pkg::FuncFree, 16'd0, 32'h1234_5678);
      send(bfsa_pkg::FuncFree, 16'hFFFF, 32'hFFFF_FFFF);
      send(bfsa_pkg::FuncFree, 16'd1, 32'h0);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 39) == 0) quiet = ~quiet;
         sel = $urandom_range(0, 99);
         if (sel < 60 || (sel < 92 && live.size() == 0)) begin
            if ($urandom_range(0, 19) == 0)
               k = $urandom_range(0, 65535);
            else if (pp == 0)
               k = 1;
            else if ($urandom_range(0, 3) == 0)
               k = $urandom_range(1, int'(pp));
            else
               k = $urandom_range(1, (pp > 8) ? int'(pp / 8) : 1);
            send(bfsa_pkg::FuncAlloc, 16'(k), $urandom());
         end else if (sel < 92) begin
            k = $urandom_range(0, live.size() - 1);
            b = live[k];
            live.delete(k);
            send(bfsa_pkg::FuncFree, b.size, b.addr);
         end else begin
            send(bfsa_pkg::FuncFree, 16'($urandom_range(0, (pp > 0) ? int'(pp) : 8)),
                 $urandom());
         end
      end
      drain();
   endtask

   task configure(logic [31:0] base, logic [16:0] ps, logic [6:0] hs, logic [16:0] lim);
      csr_write(bfsa_pkg::CsrHeapBase, base);
      csr_write(bfsa_pkg::CsrPageSize, 32'(ps));
      csr_write(bfsa_pkg::CsrHeaderSize, 32'(hs));
      csr_write(bfsa_pkg::CsrPageLimit, 32'(lim));
      csr_valid <= 0;
   endtask

   initial begin
      sb.clear();
      quiet  = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      run_phase(140);
      configure(32'hFFFF_E000, 17'd4096, 7'd16, 17'd3);    // wraps the address space
      run_phase(110);
      configure($urandom(), 17'd64, 7'd0, 17'd65536);
      run_phase(130);
      configure(32'h0000_1000, 17'd65536, 7'd64, 17'd65536);
      run_phase(110);
      configure(32'h8000_0000, 17'd65536, 7'd0, 17'd1);     // clamped page payload
      run_phase(90);
      configure(32'h0, 17'd64, 7'd64, 17'd5);               // no usable payload
      run_phase(30);
      configure($urandom(), 17'd100, 7'd7, 17'd1);
      run_phase(90);
      configure(32'h0000_0400, 17'd512, 7'd33, 17'd40);
      run_phase(130);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/bfsa_pkg.sv
rtl/core/bfsa_cell.sv
rtl/core/best_fit_segment_allocator.sv
tb/testbench.sv
